// ===== design/mdc_pkg.sv =====
// Shared types, constants and helpers of the memory dependence classifier.
package mdc_pkg;

    localparam int ADDR_BITS  = 16;
    localparam int LOC_BITS   = 32;
    localparam int ENTRY_BITS = 2 * LOC_BITS;

    typedef logic [ADDR_BITS-1:0] addr_t;
    typedef logic [LOC_BITS-1:0]  loc_t;

    typedef enum logic [1:0] {
        DEP_RAW  = 2'd0,
        DEP_WAR  = 2'd1,
        DEP_WAW  = 2'd2,
        DEP_INIT = 2'd3
    } dep_kind_t;

    typedef enum logic {
        ST_CLEAR = 1'b0,
        ST_RUN   = 1'b1
    } seq_state_t;

    typedef struct packed {
        logic        is_read;
        logic [15:0] addr;
        logic [31:0] loc_id;
        logic        skip;
        logic [31:0] var_tag;
        logic [31:0] alias_id;
    } in_word_t;

    typedef struct packed {
        dep_kind_t   dep_kind;
        logic [31:0] sink_loc;
        logic [31:0] source_loc;
        logic [31:0] dep_var_tag;
        logic [31:0] dep_alias_id;
    } out_word_t;

    typedef struct packed {
        loc_t writer;
        loc_t reader;
    } entry_t;

    typedef struct packed {
        logic   en;
        addr_t  addr;
        entry_t data;
    } mem_wr_t;

    typedef struct packed {
        logic    busy;
        mem_wr_t wr;
    } clear_t;

    typedef struct packed {
        logic      valid;
        out_word_t word;
    } result_t;

    function automatic logic [31:0] to_loc32(loc_t x);
        logic [31:0] r;
        r = '0;
        r[LOC_BITS-1:0] = x;
        return r;
    endfunction

endpackage

// ===== design/memory_dependence_classifier.sv =====
// Top level of the memory dependence classifier.
//
// The s_ channel takes one traced memory access per word: read or write flag,
// address, source location, skip flag, variable tag and alias id. The m_
// channel returns at most one dependence word per access: RAW, WAR, WAW or
// INIT, with the current and the earlier source location and the copied tags.
// Accesses that are skipped, and reads of an address without a writer, give
// no result word.
// After reset the shadow store is swept to zero, one entry per cycle, over all
// 2^ADDR_BITS entries (65536 at the default width); s_ready stays low during
// the sweep. Afterwards one access is accepted per cycle while the output is
// not stalled. The accepting edge reads the shadow RAM and loads the classify
// stage; once the output register is free, the classify stage classifies,
// writes back and loads the output register.
// Back-to-back accesses to the same address are served by forwarding the
// updated entry around the RAM. When the receiver holds m_ready low the output
// register holds its word, the classify stage stalls behind it, and s_ready
// drops while that stage holds a word, until the output register frees up.
module memory_dependence_classifier (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  mdc_pkg::in_word_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output mdc_pkg::out_word_t  m_data
);

    mdc_pkg::clear_t    clr;
    mdc_pkg::mem_wr_t   stage_wr;
    mdc_pkg::mem_wr_t   ram_wr;
    mdc_pkg::result_t   res;
    mdc_pkg::entry_t    rd_entry;
    mdc_pkg::addr_t     in_idx;
    logic [mdc_pkg::ENTRY_BITS-1:0] ram_rdata;
    logic [mdc_pkg::ENTRY_BITS-1:0] ram_wdata;
    logic               accept;
    logic               stage_ready;
    logic               advance;
    logic               out_free;
    logic               m_valid_reg, m_valid_next;
    mdc_pkg::out_word_t m_data_reg;

    assign in_idx   = mdc_pkg::addr_t'(s_data.addr);
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = !clr.busy && stage_ready;
    assign accept   = s_valid && s_ready;
    assign ram_wr   = clr.busy ? clr.wr : stage_wr;
    assign ram_wdata = ram_wr.data;
    assign rd_entry = mdc_pkg::entry_t'(ram_rdata);

    mdc_clear_seq u_clear (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clr     (clr)
    );

    mdc_shadow_ram #(
        .ADDR_W (mdc_pkg::ADDR_BITS),
        .DATA_W (mdc_pkg::ENTRY_BITS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_wr.en),
        .waddr (ram_wr.addr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (in_idx),
        .rdata (ram_rdata)
    );

    mdc_stage u_stage (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .in_word     (s_data),
        .in_idx      (in_idx),
        .rd_entry    (rd_entry),
        .out_free    (out_free),
        .stage_ready (stage_ready),
        .advance     (advance),
        .res         (res),
        .wr          (stage_wr)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = res.valid;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res.valid) begin
            m_data_reg <= res.word;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_no_accept_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        clr.busy |-> !s_ready)
        else $error("access accepted during the shadow store sweep");

    a_result_reaches_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && res.valid) |=> m_valid)
        else $error("classified result was lost before the output register");

endmodule

// ===== design/mdc_shadow_ram.sv =====
// Simple dual-port shadow RAM with one write port and one registered read port.
module mdc_shadow_ram #(
    parameter int ADDR_W = 16,
    parameter int DATA_W = 64
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [0:(1<<ADDR_W)-1];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/mdc_clear_seq.sv =====
// Post-reset sweep that zeroes every shadow entry before accesses are taken.
module mdc_clear_seq (
    input  logic            aclk,
    input  logic            aresetn,
    output mdc_pkg::clear_t clr
);

    mdc_pkg::seq_state_t state_reg, state_next;
    mdc_pkg::addr_t      addr_reg, addr_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mdc_pkg::ST_CLEAR;
            addr_reg  <= '0;
        end else begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        addr_next  = addr_reg;
        case (state_reg)
            mdc_pkg::ST_CLEAR: begin
                addr_next = addr_reg + 1'b1;
                if (addr_reg == '1) begin
                    state_next = mdc_pkg::ST_RUN;
                end
            end
            mdc_pkg::ST_RUN: begin
                state_next = mdc_pkg::ST_RUN;
            end
            default: begin
                state_next = mdc_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        clr         = '0;
        clr.wr.addr = addr_reg;
        case (state_reg)
            mdc_pkg::ST_CLEAR: begin
                clr.busy  = 1'b1;
                clr.wr.en = 1'b1;
            end
            mdc_pkg::ST_RUN: begin
                clr.busy  = 1'b0;
                clr.wr.en = 1'b0;
            end
            default: begin
                clr.busy  = 1'b1;
                clr.wr.en = 1'b0;
            end
        endcase
    end

endmodule

// ===== design/mdc_stage.sv =====
// Classify stage: selects the shadow entry or forwarded data, classifies and writes back.
module mdc_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  mdc_pkg::in_word_t in_word,
    input  mdc_pkg::addr_t    in_idx,
    input  mdc_pkg::entry_t   rd_entry,
    input  logic              out_free,
    output logic              stage_ready,
    output logic              advance,
    output mdc_pkg::result_t  res,
    output mdc_pkg::mem_wr_t  wr
);

    logic              s1_valid_reg, s1_valid_next;
    mdc_pkg::in_word_t s1_word_reg;
    mdc_pkg::addr_t    s1_idx_reg;
    logic              fwd_reg;
    mdc_pkg::entry_t   fwd_data_reg;
    mdc_pkg::entry_t   cur;
    mdc_pkg::entry_t   new_entry;
    mdc_pkg::loc_t     s1_loc;

    assign advance     = s1_valid_reg && out_free;
    assign stage_ready = !s1_valid_reg || out_free;

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (advance) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            if (accept) begin
                fwd_reg <= s1_valid_reg && (in_idx == s1_idx_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_word_reg  <= in_word;
            s1_idx_reg   <= in_idx;
            fwd_data_reg <= new_entry;
        end
    end

    always_comb begin
        s1_loc    = mdc_pkg::loc_t'(s1_word_reg.loc_id);
        cur       = fwd_reg ? fwd_data_reg : rd_entry;
        new_entry = cur;
        res       = '0;
        res.word.dep_kind     = mdc_pkg::DEP_RAW;
        res.word.sink_loc     = mdc_pkg::to_loc32(s1_loc);
        res.word.dep_var_tag  = s1_word_reg.var_tag;
        res.word.dep_alias_id = s1_word_reg.alias_id;
        if (s1_word_reg.is_read) begin
            if (s1_word_reg.skip) begin
                new_entry.reader = s1_loc;
            end else if (cur.writer != '0) begin
                new_entry.reader    = s1_loc;
                res.valid           = 1'b1;
                res.word.dep_kind   = mdc_pkg::DEP_RAW;
                res.word.source_loc = mdc_pkg::to_loc32(cur.writer);
            end
        end else begin
            new_entry.writer = s1_loc;
            if (!s1_word_reg.skip) begin
                res.valid = 1'b1;
                if (cur.writer == '0) begin
                    res.word.dep_kind = mdc_pkg::DEP_INIT;
                end else if (cur.reader != '0) begin
                    res.word.dep_kind   = mdc_pkg::DEP_WAR;
                    res.word.source_loc = mdc_pkg::to_loc32(cur.reader);
                    new_entry.reader    = '0;
                end else begin
                    res.word.dep_kind   = mdc_pkg::DEP_WAW;
                    res.word.source_loc = mdc_pkg::to_loc32(cur.writer);
                end
            end
        end
    end

    always_comb begin
        wr.en   = advance;
        wr.addr = s1_idx_reg;
        wr.data = new_entry;
    end

    a_accept_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s1_valid_reg) |-> out_free)
        else $error("word accepted while the classify stage is blocked");

    a_accept_fills_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> s1_valid_reg)
        else $error("accepted word did not reach the classify stage");

    a_init_has_no_source: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && res.valid && res.word.dep_kind == mdc_pkg::DEP_INIT)
            |-> (res.word.source_loc == '0))
        else $error("INIT result carries a nonzero source location");

endmodule
